/* src/rgbhsv_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rgbhsv_pkg
// Shared widths and constants for the RGB to HSV converter.
// ---------------------------------------------------------------------------
package rgbhsv_pkg;
  localparam int ChanBits = 16;
  localparam int HueBits  = 9;
  localparam int SatBits  = 8;
  localparam int DivSteps = 4;             // quotient bits per divide stage
  localparam logic [15:0] TolReset = 16'd10;

  typedef logic [ChanBits-1:0] chan_t;

  typedef struct packed {
    chan_t red_level;
    chan_t green_level;
    chan_t blue_level;
  } rgb_t;

  typedef struct packed {
    logic [HueBits-1:0] hue_degrees;
    logic [SatBits-1:0] saturation;
    chan_t              brightness;
    logic               achromatic;
  } hsv_t;

  // sector of the maximum channel
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_e;
endpackage
`default_nettype wire

/* src/rgbhsv_if.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rgbhsv_if
// Valid/ready channel carrying one payload item.
// ---------------------------------------------------------------------------
interface rgbhsv_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/rgbhsv_divstage.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rgbhsv_divstage
// DivSteps restoring division steps on two quotients, one dividing by spread and one by max.
// ---------------------------------------------------------------------------
module rgbhsv_divstage (
  input  logic [rgbhsv_pkg::ChanBits:0]   hrem_i,
  input  logic [15:0]                     hnum_i,
  input  logic [rgbhsv_pkg::ChanBits:0]   srem_i,
  input  logic [23:0]                     snum_i,
  input  logic [rgbhsv_pkg::ChanBits-1:0] spread_i,
  input  logic [rgbhsv_pkg::ChanBits-1:0] mx_i,
  output logic [rgbhsv_pkg::ChanBits:0]   hrem_o,
  output logic [15:0]                     hnum_o,
  output logic [rgbhsv_pkg::ChanBits:0]   srem_o,
  output logic [23:0]                     snum_o
);
  import rgbhsv_pkg::*;

  // numerator shifts out at the top while quotient bits shift in at the bottom
  always_comb begin
    logic [ChanBits+1:0] ht, st;
    hrem_o = hrem_i;
    hnum_o = hnum_i;
    srem_o = srem_i;
    snum_o = snum_i;
    for (int i = 0; i < DivSteps; i++) begin
      ht = {hrem_o, hnum_o[15]};
      hnum_o = {hnum_o[14:0], 1'b0};
      if (ht >= {2'b0, spread_i}) begin
        ht = ht - {2'b0, spread_i};
        hnum_o[0] = 1'b1;
      end
      hrem_o = ht[ChanBits:0];
      st = {srem_o, snum_o[23]};
      snum_o = {snum_o[22:0], 1'b0};
      if (st >= {2'b0, mx_i}) begin
        st = st - {2'b0, mx_i};
        snum_o[0] = 1'b1;
      end
      srem_o = st[ChanBits:0];
    end
  end
endmodule
`default_nettype wire

/* src/rgb_to_hsv_integer_core.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rgb_to_hsv_integer_core
// Integer RGB to HSV conversion, pipelined, one item per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
// Path: min/max stage, setup stage, the divide stages and the result stage, all registered.
// Throughput: one item per cycle; a stall freezes the whole pipeline.
// Depth is set by the 24-bit saturation quotient, DivSteps bits per stage.
// Reset clears valid bits and loads the grey tolerance (tol_q) with 10.
module rgb_to_hsv_integer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  rgbhsv_if.sink      in_if,
  rgbhsv_if.source    out_if
);
  import rgbhsv_pkg::*;

  localparam int NDiv = 24 / DivSteps;  // 6 divide stages
  localparam int NSt  = NDiv + 3;

  typedef struct packed {
    logic [ChanBits:0]   hrem;
    logic [15:0]         hnum;     // |diff|*60 fits 22 bits; top stays aligned
    logic [ChanBits:0]   srem;
    logic [23:0]         snum;
    chan_t               spread;
    chan_t               mx;
    logic                neg;
    sector_e             sec;
    logic                achro;
    logic                zero;
  } work_t;

  logic [15:0] tol_q;
  logic        adv;
  logic [NSt-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  assign adv         = !vld_q[NSt-1] || out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSt-2:0], in_if.valid};
    end
  end

  // stage 0: min, max, sector; channels registered for the difference
  chan_t   r0_q, g0_q, b0_q, mx0_q, mn0_q;
  sector_e sec0_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      chan_t r, g, b, mx, mn;
      r = in_if.data.red_level;
      g = in_if.data.green_level;
      b = in_if.data.blue_level;
      mn = (r < g) ? r : g;
      if (b < mn) mn = b;
      mx = (r > g) ? r : g;
      if (b > mx) mx = b;
      r0_q <= r; g0_q <= g; b0_q <= b;
      mx0_q <= mx; mn0_q <= mn;
      sec0_q <= (mx == r) ? SEC_RED : (mx == g) ? SEC_GREEN : SEC_BLUE;
    end
  end

  // stage 1: spread, times 60 and 255, set up dividers
  work_t w_q [NDiv+1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [ChanBits:0]   d;
      logic [ChanBits-1:0] ad;
      logic [21:0]         h60;
      logic [ChanBits-1:0] sp;
      case (sec0_q)
        SEC_RED:   d = {1'b0, g0_q} - {1'b0, b0_q};
        SEC_GREEN: d = {1'b0, b0_q} - {1'b0, r0_q};
        default:   d = {1'b0, r0_q} - {1'b0, g0_q};
      endcase
      ad  = d[ChanBits] ? ChanBits'(-d) : d[ChanBits-1:0];
      h60 = 22'(ad) * 22'd60;
      sp  = mx0_q - mn0_q;
      w_q[0].hrem   <= {11'b0, h60[21:16]};
      w_q[0].hnum   <= h60[15:0];
      w_q[0].srem   <= '0;
      w_q[0].snum   <= 24'(sp) * 24'd255;
      w_q[0].spread <= sp;
      w_q[0].mx     <= mx0_q;
      w_q[0].neg    <= d[ChanBits];
      w_q[0].sec    <= sec0_q;
      w_q[0].achro  <= (sp < tol_q);
      w_q[0].zero   <= (sp == '0);
    end
  end

  // hue quotient needs only 16 bits: h60 top 6 bits preloaded as remainder
  // (valid since h60/spread <= 60 means top bits < spread when spread >= 64;
  //  smaller spreads still divide correctly as the remainder is 17 bits wide
  //  and all 22 numerator bits are consumed: 6 preloaded + 16 shifted)
  for (genvar s = 0; s < NDiv; s++) begin : g_div
    logic [ChanBits:0] hr, sr;
    logic [15:0]       hn;
    logic [23:0]       sn;
    work_t             nx;
    rgbhsv_divstage u_div (
      .hrem_i   (w_q[s].hrem),
      .hnum_i   (w_q[s].hnum),
      .srem_i   (w_q[s].srem),
      .snum_i   (w_q[s].snum),
      .spread_i (w_q[s].spread),
      .mx_i     (w_q[s].mx),
      .hrem_o   (hr),
      .hnum_o   (hn),
      .srem_o   (sr),
      .snum_o   (sn)
    );
    always_comb begin
      nx = w_q[s];
      if (s >= 2) begin
        nx.hrem = hr;
        nx.hnum = hn;
      end
      nx.srem = sr;
      nx.snum = sn;
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        w_q[s+1] <= nx;
      end
    end
  end

  // last stage: offset, wrap, zero when achromatic or spread is zero
  hsv_t res_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      work_t       w;
      logic [9:0]  base, h;
      w = w_q[NDiv];
      case (w.sec)
        SEC_RED:   base = 10'd0;
        SEC_GREEN: base = 10'd120;
        default:   base = 10'd240;
      endcase
      if (w.neg) begin
        h = base - w.hnum[9:0];
        if (w.hnum[9:0] > base) h = h + 10'd360;
      end else begin
        h = base + w.hnum[9:0];
      end
      res_q.brightness <= w.mx;
      res_q.achromatic <= w.achro;
      if (w.achro || w.zero) begin
        res_q.hue_degrees <= '0;
        res_q.saturation  <= '0;
      end else begin
        res_q.hue_degrees <= h[HueBits-1:0];
        res_q.saturation  <= w.snum[SatBits-1:0];
      end
    end
  end

  assign out_if.valid = vld_q[NSt-1];
  assign out_if.data  = res_q;
endmodule
`default_nettype wire
